/* rtl/core/gvet_pkg.sv */
// Package for the graph vertex/edge table: command codes, sizes and state encoding.
// Used by gvet_vertex_store and graph_vertex_edge_table.
package gvet_pkg;

   localparam int CAPACITY_DEF     = 16;
   localparam int ID_WIDTH_DEF     = 16;
   localparam int WEIGHT_WIDTH_DEF = 16;
   localparam int SUM_WIDTH        = 20;
   localparam int COUNT_WIDTH      = 5;

   typedef enum logic [2:0] {
      CMD_ADD_VERTEX = 3'd0,
      CMD_DEL_VERTEX = 3'd1,
      CMD_FIND_VERTEX = 3'd2,
      CMD_ADD_EDGE   = 3'd3,
      CMD_DEL_EDGE   = 3'd4,
      CMD_FIND_EDGE  = 3'd5,
      CMD_INC_WEIGHT = 3'd6,
      CMD_CLEAR      = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_VSCAN,
      ST_ESCAN,
      ST_SUM,
      ST_DONE
   } state_type;

endpackage

/* rtl/core/gvet_vertex_store.sv */
// Vertex table memory with one write and one registered read port.
// Depends on gvet_pkg.
module gvet_vertex_store
   import gvet_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int ID_WIDTH = ID_WIDTH_DEF,
   localparam int AW = $clog2(CAPACITY)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  logic [ID_WIDTH-1:0] wr_data,
   input  logic [AW-1:0]       rd_addr,
   output logic [ID_WIDTH-1:0] rd_data
);

   logic [ID_WIDTH-1:0] mem [CAPACITY];
   logic [ID_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/graph_vertex_edge_table.sv */
// Graph vertex/edge table top level: command sequencer over vertex and edge memories.
// Depends on gvet_pkg and gvet_vertex_store.
// Each request runs one or more passes over a table, and the result strobe is registered
// at the end of the last pass; a vertex removal that hits runs three passes. The next
// request is taken the cycle after the strobe. Synchronous reset empties both tables;
// memories keep data.
module graph_vertex_edge_table
   import gvet_pkg::*;
#(
   parameter int CAPACITY     = CAPACITY_DEF,
   parameter int ID_WIDTH     = ID_WIDTH_DEF,
   parameter int WEIGHT_WIDTH = WEIGHT_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [2:0]              req_command,
   input  logic [ID_WIDTH-1:0]     req_vertex_id,
   input  logic [ID_WIDTH-1:0]     req_edge_id,
   input  logic [ID_WIDTH-1:0]     req_end_a,
   input  logic [ID_WIDTH-1:0]     req_end_b,
   input  logic [WEIGHT_WIDTH-1:0] req_edge_weight,
   output logic                    rsp_valid,
   output logic                    rsp_ok,
   output logic [COUNT_WIDTH-1:0]  rsp_vertex_total,
   output logic [COUNT_WIDTH-1:0]  rsp_edge_total,
   output logic [SUM_WIDTH-1:0]    rsp_weight_sum
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int EW = 3 * ID_WIDTH + WEIGHT_WIDTH;
   localparam logic [WEIGHT_WIDTH-1:0] WMAX = '1;

   state_type state_ff, state_in;
   cmd_type cmd_ff, cmd_in;
   logic [ID_WIDTH-1:0] vid_ff, vid_in, eid_ff, eid_in;
   logic [CW-1:0] vcnt_ff, vcnt_in, ecnt_ff, ecnt_in;
   logic [CW-1:0] rd_ff, rd_in, wr_ff, wr_in, lim_ff, lim_in;
   logic rdv_ff, rdv_in, ok_ff, ok_in, hit_ff, hit_in;
   logic [SUM_WIDTH-1:0] sum_ff, sum_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic v_we;
   logic [AW-1:0] v_wa, v_ra;
   logic [ID_WIDTH-1:0] v_wd, v_rd;

   logic [EW-1:0] emem [CAPACITY];
   logic [EW-1:0] e_rd_ff;
   logic e_we;
   logic [AW-1:0] e_wa, e_ra;
   logic [EW-1:0] e_wd;

   logic [ID_WIDTH-1:0] e_id, e_a, e_b;
   logic [WEIGHT_WIDTH-1:0] e_w, e_w_inc;
   cmd_type req_cmd;

   gvet_vertex_store #(.CAPACITY(CAPACITY), .ID_WIDTH(ID_WIDTH)) u_vstore (
      .clock   (clock),
      .wr_en   (v_we),
      .wr_addr (v_wa),
      .wr_data (v_wd),
      .rd_addr (v_ra),
      .rd_data (v_rd)
   );

   always_ff @(posedge clock) begin
      if (e_we) begin
         emem[e_wa] <= e_wd;
      end
      e_rd_ff <= emem[e_ra];
   end

   assign {e_id, e_a, e_b, e_w} = e_rd_ff;
   assign e_w_inc = (e_w == WMAX) ? e_w : e_w + 1'b1;
   assign req_cmd = cmd_type'(req_command);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vcnt_ff      <= '0;
         ecnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vcnt_ff      <= vcnt_in;
         ecnt_ff      <= ecnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in;
      vid_ff <= vid_in;
      eid_ff <= eid_in;
      rd_ff  <= rd_in;
      wr_ff  <= wr_in;
      lim_ff <= lim_in;
      rdv_ff <= rdv_in;
      ok_ff  <= ok_in;
      hit_ff <= hit_in;
      sum_ff <= sum_in;
   end

   // Scans read one entry per cycle (data valid in the next cycle), and removals compact by
   // writing kept entries to a trailing write pointer.
   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      vid_in = vid_ff;
      eid_in = eid_ff;
      vcnt_in = vcnt_ff;
      ecnt_in = ecnt_ff;
      rd_in = rd_ff;
      wr_in = wr_ff;
      lim_in = lim_ff;
      rdv_in = 1'b0;
      ok_in = ok_ff;
      hit_in = hit_ff;
      sum_in = sum_ff;
      rsp_valid_in = 1'b0;
      v_we = 1'b0;
      v_wa = wr_ff[AW-1:0];
      v_wd = v_rd;
      v_ra = rd_ff[AW-1:0];
      e_we = 1'b0;
      e_wa = wr_ff[AW-1:0];
      e_wd = e_rd_ff;
      e_ra = rd_ff[AW-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in = req_cmd;
               vid_in = req_vertex_id;
               eid_in = req_edge_id;
               rd_in = '0;
               wr_in = '0;
               hit_in = 1'b0;
               ok_in = 1'b0;
               state_in = ST_SUM;
               lim_in = ecnt_ff;
               unique case (req_cmd)
                  CMD_ADD_VERTEX: begin
                     if (vcnt_ff < CW'(CAPACITY)) begin
                        v_we = 1'b1;
                        v_wa = vcnt_ff[AW-1:0];
                        v_wd = req_vertex_id;
                        vcnt_in = vcnt_ff + 1'b1;
                        ok_in = 1'b1;
                     end
                  end
                  CMD_ADD_EDGE: begin
                     if (ecnt_ff < CW'(CAPACITY)) begin
                        e_we = 1'b1;
                        e_wa = ecnt_ff[AW-1:0];
                        e_wd = {req_edge_id, req_end_a, req_end_b, req_edge_weight};
                        ecnt_in = ecnt_ff + 1'b1;
                        lim_in = ecnt_ff + 1'b1;
                        ok_in = 1'b1;
                     end
                  end
                  CMD_DEL_VERTEX, CMD_FIND_VERTEX: begin
                     state_in = ST_VSCAN;
                     lim_in = vcnt_ff;
                  end
                  CMD_DEL_EDGE, CMD_FIND_EDGE, CMD_INC_WEIGHT: begin
                     state_in = ST_ESCAN;
                     ok_in = (req_cmd == CMD_INC_WEIGHT);
                  end
                  CMD_CLEAR: begin
                     vcnt_in = '0;
                     ecnt_in = '0;
                     lim_in = '0;
                     ok_in = 1'b1;
                  end
                  default: ;
               endcase
               sum_in = '0;
               rd_in = '0;
            end
         end
         ST_VSCAN: begin
            if (rd_ff < lim_ff) begin
               rd_in = rd_ff + 1'b1;
               rdv_in = 1'b1;
            end
            if (rdv_ff) begin
               if (!hit_ff && v_rd == vid_ff) begin
                  hit_in = 1'b1;
               end else begin
                  if (cmd_ff == CMD_DEL_VERTEX) begin
                     v_we = 1'b1;
                  end
                  wr_in = wr_ff + 1'b1;
               end
            end
            if (rd_ff >= lim_ff && !rdv_ff) begin
               ok_in = hit_ff;
               rd_in = '0;
               wr_in = '0;
               if (cmd_ff == CMD_DEL_VERTEX && hit_ff) begin
                  vcnt_in = vcnt_ff - 1'b1;
                  lim_in = ecnt_ff;
                  state_in = ST_ESCAN;
               end else begin
                  lim_in = ecnt_ff;
                  state_in = ST_SUM;
               end
            end
         end
         ST_ESCAN: begin
            if (rd_ff < lim_ff) begin
               rd_in = rd_ff + 1'b1;
               rdv_in = 1'b1;
            end
            if (rdv_ff) begin
               priority if (cmd_ff == CMD_DEL_VERTEX) begin
                  if (e_a != vid_ff && e_b != vid_ff) begin
                     e_we = 1'b1;
                     wr_in = wr_ff + 1'b1;
                  end
               end else if (cmd_ff == CMD_INC_WEIGHT) begin
                  e_we = 1'b1;
                  e_wd = {e_id, e_a, e_b, e_w_inc};
                  wr_in = wr_ff + 1'b1;
               end else begin
                  if (!hit_ff && e_id == eid_ff) begin
                     hit_in = 1'b1;
                  end else begin
                     e_we = (cmd_ff == CMD_DEL_EDGE);
                     wr_in = wr_ff + 1'b1;
                  end
               end
            end
            if (rd_ff >= lim_ff && !rdv_ff) begin
               priority if (cmd_ff == CMD_DEL_VERTEX || cmd_ff == CMD_DEL_EDGE) begin
                  ecnt_in = wr_ff;
                  lim_in = wr_ff;
               end else begin
                  lim_in = ecnt_ff;
               end
               if (cmd_ff == CMD_DEL_EDGE || cmd_ff == CMD_FIND_EDGE) begin
                  ok_in = hit_ff;
               end
               rd_in = '0;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            if (rd_ff < lim_ff) begin
               rd_in = rd_ff + 1'b1;
               rdv_in = 1'b1;
            end
            if (rdv_ff) begin
               sum_in = sum_ff + SUM_WIDTH'(e_w);
            end
            if (rd_ff >= lim_ff && !rdv_ff) begin
               state_in = ST_DONE;
               rsp_valid_in = 1'b1;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_ok = ok_ff;
   assign rsp_vertex_total = COUNT_WIDTH'(vcnt_ff);
   assign rsp_edge_total = COUNT_WIDTH'(ecnt_ff);
   assign rsp_weight_sum = sum_ff;

endmodule

/* verif/tb_graph_vertex_edge_table.sv */
// Self-checking testbench for graph_vertex_edge_table: directed table, then random requests.
// Depends on gvet_pkg and the graph_vertex_edge_table RTL; predicts results from its own table model.
module tb_graph_vertex_edge_table
   import gvet_pkg::*;
;

   localparam int CAP = 16;
   localparam int WMAX = 65535;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct {
      cmd_type     cmd;
      logic [15:0] vid;
      logic [15:0] eid;
      logic [15:0] ea;
      logic [15:0] eb;
      logic [15:0] w;
      bit          typed;
      logic        ok;
      logic [4:0]  vt;
      logic [4:0]  et;
      logic [19:0] sum;
   } request_row;

   typedef struct {
      logic        ok;
      logic [4:0]  vt;
      logic [4:0]  et;
      logic [19:0] sum;
   } table_result;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [2:0] req_command = '0;
   logic [15:0] req_vertex_id = '0, req_edge_id = '0, req_end_a = '0, req_end_b = '0;
   logic [15:0] req_edge_weight = '0;
   logic rsp_valid, rsp_ok;
   logic [4:0] rsp_vertex_total, rsp_edge_total;
   logic [19:0] rsp_weight_sum;

   graph_vertex_edge_table dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_vertex_id(req_vertex_id),
      .req_edge_id(req_edge_id), .req_end_a(req_end_a), .req_end_b(req_end_b),
      .req_edge_weight(req_edge_weight), .rsp_valid(rsp_valid), .rsp_ok(rsp_ok),
      .rsp_vertex_total(rsp_vertex_total), .rsp_edge_total(rsp_edge_total),
      .rsp_weight_sum(rsp_weight_sum)
   );

   always #5 clock = ~clock;

   logic [15:0] vtab[CAP];
   logic [15:0] etab_id[CAP], etab_a[CAP], etab_b[CAP], etab_w[CAP];
   int vcount = 0, ecount = 0;
   table_result pending_results[$];
   int fail_count = 0;
   int idle_cycles = 0;
   int sender_idle_pct = 0;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
      fail_count++;
   endtask

   function automatic void drop_edge_at(int pos);
      for (int j = pos; j + 1 < ecount; j++) begin
         etab_id[j] = etab_id[j + 1];
         etab_a[j] = etab_a[j + 1];
         etab_b[j] = etab_b[j + 1];
         etab_w[j] = etab_w[j + 1];
      end
      ecount--;
   endfunction

   function automatic table_result apply_command(request_row r);
      table_result res;
      int pos;
      int total;
      int k;
      res.ok = 1'b0;
      pos = -1;
      total = 0;
      k = 0;
      case (r.cmd)
         CMD_ADD_VERTEX: begin
            if (vcount < CAP) begin
               vtab[vcount] = r.vid;
               vcount++;
               res.ok = 1'b1;
            end
         end
         CMD_DEL_VERTEX: begin
            for (int i = 0; i < vcount; i++)
               if (pos < 0 && vtab[i] == r.vid) pos = i;
            if (pos >= 0) begin
               for (int j = pos; j + 1 < vcount; j++) vtab[j] = vtab[j + 1];
               vcount--;
               while (k < ecount) begin
                  if (etab_a[k] == r.vid || etab_b[k] == r.vid) drop_edge_at(k);
                  else k++;
               end
               res.ok = 1'b1;
            end
         end
         CMD_FIND_VERTEX: begin
            for (int i = 0; i < vcount; i++)
               if (vtab[i] == r.vid) res.ok = 1'b1;
         end
         CMD_ADD_EDGE: begin
            if (ecount < CAP) begin
               etab_id[ecount] = r.eid;
               etab_a[ecount] = r.ea;
               etab_b[ecount] = r.eb;
               etab_w[ecount] = r.w;
               ecount++;
               res.ok = 1'b1;
            end
         end
         CMD_DEL_EDGE: begin
            for (int i = 0; i < ecount; i++)
               if (pos < 0 && etab_id[i] == r.eid) pos = i;
            if (pos >= 0) begin
               drop_edge_at(pos);
               res.ok = 1'b1;
            end
         end
         CMD_FIND_EDGE: begin
            for (int i = 0; i < ecount; i++)
               if (etab_id[i] == r.eid) res.ok = 1'b1;
         end
         CMD_INC_WEIGHT: begin
            for (int i = 0; i < ecount; i++)
               if (etab_w[i] != WMAX) etab_w[i] = etab_w[i] + 16'd1;
            res.ok = 1'b1;
         end
         default: begin
            vcount = 0;
            ecount = 0;
            res.ok = 1'b1;
         end
      endcase
      for (int i = 0; i < ecount; i++) total += etab_w[i];
      res.vt = vcount[4:0];
      res.et = ecount[4:0];
      res.sum = total[19:0];
      return res;
   endfunction

   function automatic request_row make_row(cmd_type c, int v, int e, int a, int b, int w);
      request_row r;
      r.cmd = c;
      r.vid = 16'(v);
      r.eid = 16'(e);
      r.ea = 16'(a);
      r.eb = 16'(b);
      r.w = 16'(w);
      r.typed = 1'b0;
      r.ok = 1'b0;
      r.vt = '0;
      r.et = '0;
      r.sum = '0;
      return r;
   endfunction

   function automatic request_row typed_row(cmd_type c, int v, int e, int a, int b, int w,
                                            logic ok, int vt, int et, int sum);
      request_row r;
      r = make_row(c, v, e, a, b, w);
      r.typed = 1'b1;
      r.ok = ok;
      r.vt = 5'(vt);
      r.et = 5'(et);
      r.sum = 20'(sum);
      return r;
   endfunction

   task automatic send_request(request_row r);
      table_result want;
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) @(negedge clock);
      req_command <= r.cmd;
      req_vertex_id <= r.vid;
      req_edge_id <= r.eid;
      req_end_a <= r.ea;
      req_end_b <= r.eb;
      req_edge_weight <= r.w;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      want = apply_command(r);
      if (r.typed) begin
         if (want.ok !== r.ok || want.vt !== r.vt || want.et !== r.et || want.sum !== r.sum)
            report_mismatch("directed row", r.cmd, 0);
         want.ok = r.ok;
         want.vt = r.vt;
         want.et = r.et;
         want.sum = r.sum;
      end
      pending_results.push_back(want);
      @(negedge clock);
      start <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", 1, 0);
         end else begin
            table_result want;
            want = pending_results.pop_front();
            if (rsp_ok !== want.ok) report_mismatch("ok", rsp_ok, want.ok);
            if (rsp_vertex_total !== want.vt)
               report_mismatch("vertex_total", rsp_vertex_total, want.vt);
            if (rsp_edge_total !== want.et)
               report_mismatch("edge_total", rsp_edge_total, want.et);
            if (rsp_weight_sum !== want.sum)
               report_mismatch("weight_sum", rsp_weight_sum, want.sum);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_graph_vertex_edge_table: FAIL");
            $finish;
         end
      end
   end

   function automatic int pick_id();
      // Small id pool so searches and removals hit often; sometimes a full-range id.
      if ($urandom_range(9) == 0) return $urandom_range(65535);
      return $urandom_range(7) | ($urandom_range(1) ? 16'hfff0 : 16'h0);
   endfunction

   function automatic request_row random_row();
      cmd_type c;
      int sel;
      int w;
      sel = $urandom_range(99);
      if (sel < 22) c = CMD_ADD_VERTEX;
      else if (sel < 32) c = CMD_DEL_VERTEX;
      else if (sel < 42) c = CMD_FIND_VERTEX;
      else if (sel < 66) c = CMD_ADD_EDGE;
      else if (sel < 78) c = CMD_DEL_EDGE;
      else if (sel < 88) c = CMD_FIND_EDGE;
      else if (sel < 97) c = CMD_INC_WEIGHT;
      else c = CMD_CLEAR;
      w = $urandom_range(3) == 0 ? 65535 - $urandom_range(3) : $urandom_range(65535);
      return make_row(c, pick_id(), pick_id(), pick_id(), pick_id(), w);
   endfunction

   request_row directed[$];
   int phase_pct[4] = '{0, 69, 0, 35};

   initial begin
      directed.push_back(typed_row(CMD_FIND_VERTEX, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(typed_row(CMD_DEL_VERTEX, 65535, 0, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(typed_row(CMD_FIND_EDGE, 0, 65535, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(typed_row(CMD_DEL_EDGE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(typed_row(CMD_INC_WEIGHT, 0, 0, 0, 0, 0, 1, 0, 0, 0));
      directed.push_back(typed_row(CMD_ADD_EDGE, 0, 65535, 1, 2, 65535, 1, 0, 1, 65535));
      directed.push_back(typed_row(CMD_INC_WEIGHT, 0, 0, 0, 0, 0, 1, 0, 1, 65535));
      directed.push_back(make_row(CMD_ADD_EDGE, 0, 7, 65535, 1, 0));
      directed.push_back(make_row(CMD_ADD_EDGE, 0, 7, 3, 3, 65534));
      directed.push_back(make_row(CMD_ADD_VERTEX, 65535, 0, 0, 0, 0));
      directed.push_back(make_row(CMD_ADD_VERTEX, 1, 0, 0, 0, 0));
      directed.push_back(make_row(CMD_ADD_VERTEX, 1, 0, 0, 0, 0));
      directed.push_back(make_row(CMD_FIND_EDGE, 0, 65535, 0, 0, 0));
      directed.push_back(make_row(CMD_INC_WEIGHT, 0, 0, 0, 0, 0));
      directed.push_back(make_row(CMD_DEL_EDGE, 0, 7, 0, 0, 0));
      directed.push_back(make_row(CMD_DEL_VERTEX, 1, 0, 0, 0, 0));
      directed.push_back(make_row(CMD_FIND_VERTEX, 1, 0, 0, 0, 0));
      directed.push_back(make_row(CMD_DEL_VERTEX, 9, 0, 0, 0, 0));
      directed.push_back(typed_row(CMD_CLEAR, 0, 0, 0, 0, 0, 1, 0, 0, 0));
      for (int i = 0; i < CAP + 1; i++)
         directed.push_back(make_row(CMD_ADD_VERTEX, i, 0, 0, 0, 0));
      for (int i = 0; i < CAP + 1; i++)
         directed.push_back(make_row(CMD_ADD_EDGE, 0, i, i, 65535 - i, 65535));
      directed.push_back(make_row(CMD_INC_WEIGHT, 0, 0, 0, 0, 0));
      directed.push_back(make_row(CMD_CLEAR, 0, 0, 0, 0, 0));

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_request(directed[i]);
      for (int p = 0; p < 4; p++) begin
         sender_idle_pct = phase_pct[p];
         for (int k = 0; k < 150; k++) send_request(random_row());
         // Let the block drain fully before the next phase.
         while (pending_results.size() != 0) @(negedge clock);
      end

      while (pending_results.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      if (fail_count == 0) begin
         $display("tb_graph_vertex_edge_table: PASS");
      end else begin
         $display("tb_graph_vertex_edge_table: FAIL");
      end
      $finish;
   end
endmodule
